// ===== rtl/eia_pkg.sv =====
// Package for the 64-bit integer ALU: opcodes, status codes and beat types.
// No dependencies; used by euclidean_int64_alu.
`timescale 1ns / 1ps

package eia_pkg;

    localparam int unsigned WordBits = 64;
    localparam int unsigned HalfBits = WordBits / 2;
    localparam int unsigned ShiftBits = $clog2(WordBits);
    localparam int unsigned DivStages = WordBits;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_IDIV = 5'd3,
        OP_MOD  = 5'd4,
        OP_AND  = 5'd5,
        OP_OR   = 5'd6,
        OP_XOR  = 5'd7,
        OP_SHL  = 5'd8,
        OP_SHR  = 5'd9,
        OP_NOT  = 5'd10,
        OP_NEG  = 5'd11,
        OP_EQ   = 5'd12,
        OP_NE   = 5'd13,
        OP_LT   = 5'd14,
        OP_LE   = 5'd15,
        OP_GT   = 5'd16,
        OP_GE   = 5'd17
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIV_ZERO  = 2'd1,
        ST_NEG_SHIFT = 2'd2
    } status_t;

    // Request beat
    typedef struct packed {
        logic [4:0]                 opcode;
        logic signed [WordBits-1:0] operand_a;
        logic signed [WordBits-1:0] operand_b;
    } alu_req_t;

    // Response beat
    typedef struct packed {
        logic signed [WordBits-1:0] result;
        logic [1:0]                 status;
    } alu_rsp_t;

endpackage

// ===== rtl/euclidean_int64_alu.sv =====
// Pipelined 64-bit integer ALU with truncating divide and Euclidean modulo.
// Every opcode takes the same path: input register, stage 1, stage 2, the divider stages,
// then the output register, which drives strobe and response.
// Throughput: one beat per cycle; busy stays low. The 64-stage restoring divider
// (one quotient bit per stage) sets the depth, and every beat walks through it to keep order.
// Reset: rst_n clears all valid bits asynchronously; no results are in flight after it.
// Depends on eia_pkg.
`timescale 1ns / 1ps

module euclidean_int64_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  eia_pkg::alu_req_t request,
    output logic              strobe,
    output eia_pkg::alu_rsp_t response
);
    import eia_pkg::*;

    // Payload carried alongside the divider
    typedef struct packed {
        logic [4:0]          op;
        logic                a_neg;
        logic                b_neg;
        logic [WordBits-1:0] mb;
        logic [WordBits-1:0] res;
        logic [1:0]          st;
    } carry_t;

    // Input register
    logic                s0_valid_reg;
    alu_req_t            s0_reg;

    // Stage 1: simple ops, magnitudes, partial products
    logic                s1_valid_reg;
    carry_t              s1_reg;
    logic [WordBits-1:0] s1_ma_reg;
    logic [WordBits-1:0] s1_pll_reg;
    logic [HalfBits-1:0] s1_plh_reg;
    logic [HalfBits-1:0] s1_phl_reg;

    // Divider stage arrays (index 0 loaded by stage 2)
    logic                dv_valid_reg [0:DivStages];
    carry_t              dv_reg       [0:DivStages];
    logic [WordBits-1:0] dv_rem_reg   [0:DivStages];
    logic [WordBits-1:0] dv_quo_reg   [0:DivStages];

    // Output register
    logic                out_valid_reg;
    logic [4:0]          out_op_reg;
    alu_rsp_t            out_reg;

    logic [WordBits-1:0] a_w, b_w;
    logic [WordBits-1:0] simple_res;
    logic [1:0]          simple_st;
    logic                a_neg, b_neg;
    logic                big_shift;
    carry_t              s1_next;
    logic [WordBits-1:0] mul_next;
    carry_t              dv0_next;
    logic [WordBits-1:0] fin_quo, fin_rem, fin_res;
    carry_t              fin;

    assign busy = 1'b0;

    // Input capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s0_reg <= request;
        end
    end

    // Stage 1 logic: everything but mul and the divide
    assign a_w       = s0_reg.operand_a;
    assign b_w       = s0_reg.operand_b;
    assign a_neg     = a_w[WordBits-1];
    assign b_neg     = b_w[WordBits-1];
    assign big_shift = |b_w[WordBits-2:ShiftBits];

    always_comb
    begin
        simple_res = '0;
        simple_st  = ST_OK;
        unique case (s0_reg.opcode)
            OP_ADD:  simple_res = a_w + b_w;
            OP_SUB:  simple_res = a_w - b_w;
            OP_IDIV,
            OP_MOD:  simple_st = (b_w == '0) ? ST_DIV_ZERO : ST_OK;
            OP_AND:  simple_res = a_w & b_w;
            OP_OR:   simple_res = a_w | b_w;
            OP_XOR:  simple_res = a_w ^ b_w;
            OP_SHL:
            begin
                if (b_neg)
                    simple_st = ST_NEG_SHIFT;
                else if (!big_shift)
                    simple_res = a_w << b_w[ShiftBits-1:0];
            end
            OP_SHR:
            begin
                if (b_neg)
                    simple_st = ST_NEG_SHIFT;
                else if (big_shift)
                    simple_res = {WordBits{a_neg}};
                else
                    simple_res = $signed(a_w) >>> b_w[ShiftBits-1:0];
            end
            OP_NOT:  simple_res = ~a_w;
            OP_NEG:  simple_res = WordBits'(0) - a_w;
            OP_EQ:   simple_res = WordBits'(a_w == b_w);
            OP_NE:   simple_res = WordBits'(a_w != b_w);
            OP_LT:   simple_res = WordBits'($signed(a_w) < $signed(b_w));
            OP_LE:   simple_res = WordBits'($signed(a_w) <= $signed(b_w));
            OP_GT:   simple_res = WordBits'($signed(a_w) > $signed(b_w));
            OP_GE:   simple_res = WordBits'($signed(a_w) >= $signed(b_w));
            default: simple_res = '0;
        endcase
    end

    always_comb
    begin
        s1_next.op    = s0_reg.opcode;
        s1_next.a_neg = a_neg;
        s1_next.b_neg = b_neg;
        s1_next.mb    = b_neg ? (WordBits'(0) - b_w) : b_w;
        s1_next.res   = simple_res;
        s1_next.st    = simple_st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg     <= s1_next;
        s1_ma_reg  <= a_neg ? (WordBits'(0) - a_w) : a_w;
        s1_pll_reg <= a_w[HalfBits-1:0] * b_w[HalfBits-1:0];
        s1_plh_reg <= HalfBits'(a_w[HalfBits-1:0] * b_w[WordBits-1:HalfBits]);
        s1_phl_reg <= HalfBits'(a_w[WordBits-1:HalfBits] * b_w[HalfBits-1:0]);
    end

    // Stage 2: fold partial products into the low product word
    assign mul_next = s1_pll_reg + {s1_plh_reg + s1_phl_reg, {HalfBits{1'b0}}};

    always_comb
    begin
        dv0_next = s1_reg;
        if (s1_reg.op == OP_MUL)
            dv0_next.res = mul_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0]     <= dv0_next;
        dv_rem_reg[0] <= '0;
        dv_quo_reg[0] <= s1_ma_reg;
    end

    // Restoring divider: one quotient bit per stage
    for (genvar k = 0; k < DivStages; k++)
    begin : g_div
        logic [WordBits-1:0] shifted;
        logic                ge;

        assign shifted = {dv_rem_reg[k][WordBits-2:0], dv_quo_reg[k][WordBits-1]};
        assign ge      = shifted >= dv_reg[k].mb;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[k+1]     <= dv_reg[k];
            dv_rem_reg[k+1] <= ge ? (shifted - dv_reg[k].mb) : shifted;
            dv_quo_reg[k+1] <= {dv_quo_reg[k][WordBits-2:0], ge};
        end
    end

    // Final stage: zero result on error status, sign fix for divide, Euclidean fix for modulo
    assign fin     = dv_reg[DivStages];
    assign fin_quo = dv_quo_reg[DivStages];
    assign fin_rem = dv_rem_reg[DivStages];

    always_comb
    begin
        fin_res = fin.res;
        if (fin.st != ST_OK)
            fin_res = '0;
        else if (fin.op == OP_IDIV)
            fin_res = (fin.a_neg != fin.b_neg) ? (WordBits'(0) - fin_quo) : fin_quo;
        else if (fin.op == OP_MOD)
            fin_res = (fin.a_neg && fin_rem != '0) ? (fin.mb - fin_rem) : fin_rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= dv_valid_reg[DivStages];
        end
    end

    always_ff @(posedge clk)
    begin
        out_op_reg     <= fin.op;
        out_reg.result <= fin_res;
        out_reg.status <= fin.st;
    end

    assign strobe   = out_valid_reg;
    assign response = out_reg;

    // Checks
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> s0_valid_reg)
        else $error("accepted beat not captured");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && response.status != ST_OK) |-> (response.result == '0))
        else $error("error beat with nonzero result");

    a_cmp_bool: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (out_op_reg == OP_EQ || out_op_reg == OP_NE || out_op_reg == OP_LT ||
                    out_op_reg == OP_LE || out_op_reg == OP_GT || out_op_reg == OP_GE))
        |-> (response.result[WordBits-1:1] == '0))
        else $error("compare result not 0 or 1");

    a_divz_op: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && response.status == ST_DIV_ZERO) |->
        (out_op_reg == OP_IDIV || out_op_reg == OP_MOD))
        else $error("divide-by-zero status on non-divide op");

    a_mod_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && out_op_reg == OP_MOD) |-> !response.result[WordBits-1])
        else $error("negative modulo result");

endmodule

// ===== dv/euclidean_int64_alu_tb.sv =====
// Testbench for euclidean_int64_alu: directed corner beats, then random beats
// across sender idle phases, checked in order against a built-in predictor.
// Depends on eia_pkg and the RTL of euclidean_int64_alu.
`timescale 1ns / 1ps

// Scoreboard: holds predicted responses in issue order
class alu_scoreboard;
    eia_pkg::alu_rsp_t pending_rsp[$];
    int unsigned errors;
    int unsigned checked;

    // Predict one response from a request beat
    function eia_pkg::alu_rsp_t compute(eia_pkg::alu_req_t rq);
        eia_pkg::alu_rsp_t rs;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        a = rq.operand_a;
        b = rq.operand_b;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        rs.result = '0;
        rs.status = eia_pkg::ST_OK;
        case (rq.opcode)
            eia_pkg::OP_ADD: rs.result = a + b;
            eia_pkg::OP_SUB: rs.result = a - b;
            eia_pkg::OP_MUL: rs.result = a * b;
            eia_pkg::OP_IDIV, eia_pkg::OP_MOD:
            begin
                if (b == 0)
                    rs.status = eia_pkg::ST_DIV_ZERO;
                else if (rq.opcode == eia_pkg::OP_IDIV)
                begin
                    q = ma / mb;
                    rs.result = (a[63] != b[63]) ? -q : q;
                end
                else
                begin
                    // Euclidean: remainder folded into [0, |b|)
                    q = ma % mb;
                    if (a[63] && q != 0)
                        q = mb - q;
                    rs.result = q;
                end
            end
            eia_pkg::OP_AND: rs.result = a & b;
            eia_pkg::OP_OR:  rs.result = a | b;
            eia_pkg::OP_XOR: rs.result = a ^ b;
            eia_pkg::OP_SHL, eia_pkg::OP_SHR:
            begin
                if (b[63])
                    rs.status = eia_pkg::ST_NEG_SHIFT;
                else if (rq.opcode == eia_pkg::OP_SHL)
                    rs.result = (b >= 64) ? 64'd0 : (a << b[5:0]);
                else if (b >= 64)
                    rs.result = {64{a[63]}};
                else
                    rs.result = a >>> b[5:0];
            end
            eia_pkg::OP_NOT: rs.result = ~a;
            eia_pkg::OP_NEG: rs.result = -a;
            eia_pkg::OP_EQ:  rs.result = (a == b);
            eia_pkg::OP_NE:  rs.result = (a != b);
            eia_pkg::OP_LT:  rs.result = (a < b);
            eia_pkg::OP_LE:  rs.result = (a <= b);
            eia_pkg::OP_GT:  rs.result = (a > b);
            eia_pkg::OP_GE:  rs.result = (a >= b);
            default: ;
        endcase
        return rs;
    endfunction

    function void note_request(eia_pkg::alu_req_t rq);
        pending_rsp.push_back(compute(rq));
    endfunction

    function void check_response(eia_pkg::alu_rsp_t got);
        eia_pkg::alu_rsp_t exp_rsp;
        if (pending_rsp.size() == 0)
        begin
            $display("%0t: unexpected response result=%h status=%0d",
                     $time, got.result, got.status);
            errors++;
            return;
        end
        exp_rsp = pending_rsp.pop_front();
        checked++;
        if (got.result !== exp_rsp.result)
        begin
            $display("%0t: result mismatch expected %h actual %h",
                     $time, exp_rsp.result, got.result);
            errors++;
        end
        if (got.status !== exp_rsp.status)
        begin
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, exp_rsp.status, got.status);
            errors++;
        end
    endfunction
endclass

module euclidean_int64_alu_tb;
    import eia_pkg::*;

    localparam logic signed [63:0] MinVal = 64'h8000_0000_0000_0000;
    localparam logic signed [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    alu_req_t request;
    logic     strobe;
    alu_rsp_t response;

    alu_scoreboard sb;
    int unsigned idle_pct;
    int unsigned n_sent;

    euclidean_int64_alu u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .strobe   (strobe),
        .response (response)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Check every strobed beat
    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
            sb.check_response(response);
    end

    // Drive one beat, idling first at the current rate; returns after acceptance
    task automatic send_beat(input logic [4:0] op, input logic signed [63:0] a,
                             input logic signed [63:0] b);
        alu_req_t rq;
        rq.opcode = op;
        rq.operand_a = a;
        rq.operand_b = b;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_request(rq);
        n_sent++;
    endtask

    // Random operand biased toward corners and small values
    function automatic logic signed [63:0] pick_operand();
        logic signed [63:0] v;
        case ($urandom_range(9))
            0: v = MinVal;
            1: v = MaxVal;
            2: v = $signed(64'($urandom_range(4))) - 2;
            3: v = $signed(64'($urandom_range(140))) - 70;
            4: v = {$urandom, $urandom} >> $urandom_range(63);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic send_random();
        logic [4:0] op;
        logic signed [63:0] b;
        op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 18))
                                       : 5'($urandom_range(17));
        b = pick_operand();
        if ((op == OP_SHL || op == OP_SHR) && $urandom_range(2) != 0)
            b = $urandom_range(70);
        send_beat(op, pick_operand(), b);
    endtask

    initial
    begin
        #20_000_000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned waited;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        idle_pct = 0;
        n_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: every opcode and each special case
        send_beat(OP_ADD, MaxVal, 64'sd1);
        send_beat(OP_SUB, MinVal, 64'sd1);
        send_beat(OP_MUL, MaxVal, MinVal);
        send_beat(OP_IDIV, -64'sd7, 64'sd2);
        send_beat(OP_IDIV, 64'sd5, 64'sd0);
        send_beat(OP_IDIV, MinVal, -64'sd1);
        send_beat(OP_MOD, -64'sd7, 64'sd3);
        send_beat(OP_MOD, -64'sd7, -64'sd3);
        send_beat(OP_MOD, MinVal, -64'sd1);
        send_beat(OP_MOD, MinVal, 64'sd0);
        send_beat(OP_AND, -64'sd1, MinVal);
        send_beat(OP_OR, MaxVal, MinVal);
        send_beat(OP_XOR, -64'sd1, MaxVal);
        send_beat(OP_SHL, -64'sd1, 64'sd63);
        send_beat(OP_SHL, 64'sd1, 64'sd64);
        send_beat(OP_SHL, 64'sd1, -64'sd1);
        send_beat(OP_SHR, MinVal, 64'sd63);
        send_beat(OP_SHR, MinVal, MaxVal);
        send_beat(OP_SHR, 64'sd9, MinVal);
        send_beat(OP_NOT, 64'sd0, -64'sd1);
        send_beat(OP_NEG, MinVal, 64'sd0);
        send_beat(OP_EQ, MinVal, MinVal);
        send_beat(OP_NE, MinVal, MaxVal);
        send_beat(OP_LT, MinVal, MaxVal);
        send_beat(OP_LE, MaxVal, MaxVal);
        send_beat(OP_GT, -64'sd1, 64'sd0);
        send_beat(OP_GE, MinVal, MaxVal);
        send_beat(5'd31, -64'sd1, -64'sd1);

        // Random phases with varying sender idle rate
        idle_pct = 0;
        repeat (400) send_random();
        idle_pct = 54;
        repeat (300) send_random();
        idle_pct = 14;
        repeat (300) send_random();
        idle_pct = 0;
        repeat (250) send_random();
        start <= 1'b0;

        // Drain, then a latency-sized quiet window
        waited = 0;
        while (sb.pending_rsp.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (80) @(posedge clk);

        $display("Sent %0d beats covering all opcodes, unused codes and corner operands;",
                 n_sent);
        $display("%0d responses checked, %0d errors", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/eia_pkg.sv
rtl/euclidean_int64_alu.sv
dv/euclidean_int64_alu_tb.sv
